// ===== rtl/core/olis_pkg.sv =====
package olis_pkg;

    localparam int LIMB_W = 64;
    localparam int PROD_W = 2 * LIMB_W;
    localparam int HALF_W = LIMB_W / 2;
    localparam int COUNT_W = 7;

    // Inverses of the odd bytes modulo 256, indexed by bits 7:1 of the byte.
    localparam logic [7:0] SEED_INV [128] = '{
        8'd1,   8'd171, 8'd205, 8'd183, 8'd57,  8'd163, 8'd197, 8'd239,
        8'd241, 8'd27,  8'd61,  8'd167, 8'd41,  8'd19,  8'd53,  8'd223,
        8'd225, 8'd139, 8'd173, 8'd151, 8'd25,  8'd131, 8'd165, 8'd207,
        8'd209, 8'd251, 8'd29,  8'd135, 8'd9,   8'd243, 8'd21,  8'd191,
        8'd193, 8'd107, 8'd141, 8'd119, 8'd249, 8'd99,  8'd133, 8'd175,
        8'd177, 8'd219, 8'd253, 8'd103, 8'd233, 8'd211, 8'd245, 8'd159,
        8'd161, 8'd75,  8'd109, 8'd87,  8'd217, 8'd67,  8'd101, 8'd143,
        8'd145, 8'd187, 8'd221, 8'd71,  8'd201, 8'd179, 8'd213, 8'd127,
        8'd129, 8'd43,  8'd77,  8'd55,  8'd185, 8'd35,  8'd69,  8'd111,
        8'd113, 8'd155, 8'd189, 8'd39,  8'd169, 8'd147, 8'd181, 8'd95,
        8'd97,  8'd11,  8'd45,  8'd23,  8'd153, 8'd3,   8'd37,  8'd79,
        8'd81,  8'd123, 8'd157, 8'd7,   8'd137, 8'd115, 8'd149, 8'd63,
        8'd65,  8'd235, 8'd13,  8'd247, 8'd121, 8'd227, 8'd5,   8'd47,
        8'd49,  8'd91,  8'd125, 8'd231, 8'd105, 8'd83,  8'd117, 8'd31,
        8'd33,  8'd203, 8'd237, 8'd215, 8'd89,  8'd195, 8'd229, 8'd15,
        8'd17,  8'd59,  8'd93,  8'd199, 8'd73,  8'd51,  8'd85,  8'd255
    };

    typedef struct packed {
        logic              start;
        logic [LIMB_W-1:0] x;
        logic [LIMB_W-1:0] y;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    function automatic logic [7:0] seed_lookup(input logic [6:0] idx);
        seed_lookup = SEED_INV[idx];
    endfunction

endpackage

// ===== rtl/core/olis_ifs.sv =====
interface olis_in_if;
    logic                          valid;
    logic                          ready;
    logic [olis_pkg::LIMB_W-1:0]   operand;
    logic [olis_pkg::COUNT_W-1:0]  limb_count;

    modport source (output valid, output operand, output limb_count, input ready);
    modport sink (input valid, input operand, input limb_count, output ready);
endinterface

interface olis_out_if;
    logic                          valid;
    logic                          ready;
    logic [olis_pkg::LIMB_W-1:0]   limb;
    logic                          last;
    logic                          error;

    modport source (output valid, output limb, output last, output error, input ready);
    modport sink (input valid, input limb, input last, input error, output ready);
endinterface

// ===== rtl/core/olis_mul.sv =====
module olis_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  olis_pkg::mul_req_t req,
    output olis_pkg::mul_rsp_t rsp
);
    import olis_pkg::*;

    logic [LIMB_W-1:0] x_reg;
    logic [LIMB_W-1:0] y_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [LIMB_W-1:0] pp_reg;
    logic [1:0]        sh_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [HALF_W-1:0] xs;
    logic [HALF_W-1:0] ys;
    logic [PROD_W-1:0] pp_shifted;

    // Partial products in the order lo*lo, lo*hi, hi*lo, hi*hi.
    assign xs = cnt_reg[1] ? x_reg[LIMB_W-1:HALF_W] : x_reg[HALF_W-1:0];
    assign ys = cnt_reg[0] ? y_reg[LIMB_W-1:HALF_W] : y_reg[HALF_W-1:0];

    always_comb
    begin
        unique case (sh_reg)
            2'd0:    pp_shifted = {{LIMB_W{1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            2'd2:    pp_shifted = {pp_reg, {LIMB_W{1'b0}}};
            default: pp_shifted = {PROD_W{1'b0}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= {PROD_W{1'b0}};
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= xs * ys;
                sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== rtl/core/odd_limb_inverse_limb_stream_unit.sv =====
// Channel | Dir  | Payload                        | Transfer when
// in_ch   | sink | operand[63:0], limb_count[6:0] | valid && ready
// out_ch  | src  | limb[63:0], last, error        | valid && ready
//
// Every 64-bit product goes through one shared 32x32 multiplier, four partial
// products accumulated into a 128-bit register. The first limb needs a seed
// lookup and six products; each later limb needs two dependent products.
// An even operand goes straight from idle to the emit state and then gives its
// single error result through the output register.
// Input is accepted only when idle; a stalled output holds the sequencer.
// Asynchronous active-low reset returns the block to idle with no output.
module odd_limb_inverse_limb_stream_unit #(
    parameter int MAX_LIMBS = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    olis_in_if.sink   in_ch,
    olis_out_if.source out_ch
);
    import olis_pkg::*;

    localparam int CNT_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS + 1) : 1;
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_MUL   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    // Newton steps on the seed, then the limb loop (P: next limb, K: carry).
    typedef enum logic [2:0] {
        OP_E0 = 3'd0,
        OP_R1 = 3'd1,
        OP_E1 = 3'd2,
        OP_R2 = 3'd3,
        OP_E2 = 3'd4,
        OP_R3 = 3'd5,
        OP_P  = 3'd6,
        OP_K  = 3'd7
    } op_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [LIMB_W-1:0] a_reg, a_next;
    logic [LIMB_W-1:0] r_reg, r_next;
    logic [LIMB_W-1:0] e_reg, e_next;
    logic [LIMB_W-1:0] k_reg, k_next;
    logic [LIMB_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [LIMB_W-1:0] out_limb_reg, out_limb_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;

    mul_req_t          mreq;
    mul_rsp_t          mrsp;
    logic [LIMB_W-1:0] lo;
    logic [LIMB_W-1:0] hi;
    logic [LIMB_W:0]   carry_sum;
    logic [CMP_W-1:0]  n_ext;
    logic [CMP_W-1:0]  n_clamped;
    logic              is_last;
    logic              out_free;

    olis_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign lo        = mrsp.prod[LIMB_W-1:0];
    assign hi        = mrsp.prod[PROD_W-1:LIMB_W];
    assign carry_sum = {1'b0, k_reg} + {1'b0, lo};
    assign is_last   = err_reg || (rem_reg == CNT_W'(1));
    assign out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        n_ext = CMP_W'(in_ch.limb_count);
        priority if (n_ext == '0)
            n_clamped = CMP_W'(1);
        else if (n_ext > CMP_W'(MAX_LIMBS))
            n_clamped = CMP_W'(MAX_LIMBS);
        else
            n_clamped = n_ext;
    end

    always_comb
    begin
        mreq.start = (state_reg == S_ISSUE);
        unique case (op_reg)
            OP_E0:
            begin
                mreq.x = a_reg;
                mreq.y = r_reg;
            end
            OP_R1, OP_R2, OP_R3:
            begin
                mreq.x = r_reg;
                mreq.y = e_reg + LIMB_W'(1);
            end
            OP_E1, OP_E2:
            begin
                mreq.x = e_reg;
                mreq.y = e_reg;
            end
            OP_P:
            begin
                mreq.x = {LIMB_W{1'b0}} - r_reg;
                mreq.y = k_reg;
            end
            OP_K:
            begin
                mreq.x = p_reg;
                mreq.y = a_reg;
            end
            default:
            begin
                mreq.x = a_reg;
                mreq.y = r_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_limb_next  = out_limb_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    a_next   = in_ch.operand;
                    rem_next = CNT_W'(n_clamped);
                    r_next   = {{(LIMB_W-8){1'b0}}, seed_lookup(in_ch.operand[7:1])};
                    op_next  = OP_E0;
                    if (!in_ch.operand[0])
                    begin
                        err_next   = 1'b1;
                        p_next     = {LIMB_W{1'b0}};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mrsp.done)
                begin
                    state_next = S_ISSUE;
                    unique case (op_reg)
                        OP_E0:
                        begin
                            e_next  = LIMB_W'(1) - lo;
                            op_next = OP_R1;
                        end
                        OP_R1:
                        begin
                            r_next  = lo;
                            op_next = OP_E1;
                        end
                        OP_E1:
                        begin
                            e_next  = lo;
                            op_next = OP_R2;
                        end
                        OP_R2:
                        begin
                            r_next  = lo;
                            op_next = OP_E2;
                        end
                        OP_E2:
                        begin
                            e_next  = lo;
                            op_next = OP_R3;
                        end
                        OP_R3:
                        begin
                            // The first carry is the high half of inv*a, which
                            // the carry step gives when started from zero.
                            r_next     = lo;
                            p_next     = lo;
                            k_next     = {LIMB_W{1'b0}};
                            state_next = S_EMIT;
                        end
                        OP_P:
                        begin
                            p_next     = lo;
                            state_next = S_EMIT;
                        end
                        OP_K:
                        begin
                            k_next  = hi + LIMB_W'(carry_sum[LIMB_W]);
                            op_next = OP_P;
                        end
                        default:
                        begin
                            op_next = OP_E0;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_limb_next  = p_reg;
                    out_last_next  = is_last;
                    out_err_next   = err_reg;
                    rem_next       = rem_reg - CNT_W'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op_next    = OP_K;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_E0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        r_reg        <= r_next;
        e_reg        <= e_next;
        k_reg        <= k_next;
        p_reg        <= p_next;
        out_limb_reg <= out_limb_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.limb  = out_limb_reg;
    assign out_ch.last  = out_last_reg;
    assign out_ch.error = out_err_reg;

endmodule

// ===== rtl/core/olis_chk.sv =====
module olis_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [olis_pkg::LIMB_W-1:0] out_limb,
    input logic                        out_last,
    input logic                        out_error
);
    import olis_pkg::*;

    // A result with the error flag closes its run and carries a zero limb.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_last && (out_limb == {LIMB_W{1'b0}}))
        else $error("error result is not a final zero limb");

    // Once an operand has been taken, no further one is taken in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A result can never appear in the cycle straight after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early after an input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_limb)
            && $stable(out_last) && $stable(out_error))
        else $error("stalled result changed or was dropped");

endmodule

bind odd_limb_inverse_limb_stream_unit olis_chk u_olis_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_limb  (out_ch.limb),
    .out_last  (out_ch.last),
    .out_error (out_ch.error)
);

// ===== bench/odd_limb_inverse_limb_stream_unit_tb.sv =====
module odd_limb_inverse_limb_stream_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olis_pkg::*;

    localparam int MAX_LIMBS = 64;
    localparam int RANDOM_ITEMS = 140;
    localparam int SILENCE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int DIRECTED_ROWS = 19;

    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic              last;
        logic              error;
    } limb_result_t;

    typedef struct packed {
        logic [LIMB_W-1:0]  operand;
        logic [COUNT_W-1:0] count;
        logic               typed;
        limb_result_t       want;
    } stim_row_t;

    // Rows with typed set carry their single expected result; the rest go to the predictor.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        {64'h0000_0000_0000_0001, 7'd1,   1'b1, {64'h0000_0000_0000_0001, 1'b1, 1'b0}},
        {64'hFFFF_FFFF_FFFF_FFFF, 7'd1,   1'b1, {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
        {64'h0000_0000_0000_0003, 7'd0,   1'b1, {64'hAAAA_AAAA_AAAA_AAAB, 1'b1, 1'b0}},
        {64'h0000_0000_0000_0000, 7'd1,   1'b1, {64'h0000_0000_0000_0000, 1'b1, 1'b1}},
        {64'hFFFF_FFFF_FFFF_FFFE, 7'd127, 1'b1, {64'h0000_0000_0000_0000, 1'b1, 1'b1}},
        {64'h8000_0000_0000_0000, 7'd64,  1'b1, {64'h0000_0000_0000_0000, 1'b1, 1'b1}},
        {64'h0000_0000_0000_0002, 7'd0,   1'b1, {64'h0000_0000_0000_0000, 1'b1, 1'b1}},
        {64'h0000_0000_0000_0001, 7'd2,   1'b0, 66'd0},
        {64'h0000_0000_0000_0001, 7'd64,  1'b0, 66'd0},
        {64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  1'b0, 66'd0},
        {64'h8000_0000_0000_0001, 7'd5,   1'b0, 66'd0},
        {64'h7FFF_FFFF_FFFF_FFFF, 7'd2,   1'b0, 66'd0},
        {64'h5555_5555_5555_5555, 7'd127, 1'b0, 66'd0},
        {64'hAAAA_AAAA_AAAA_AAAB, 7'd65,  1'b0, 66'd0},
        {64'h0123_4567_89AB_CDEF, 7'd3,   1'b0, 66'd0},
        {64'hFEDC_BA98_7654_3211, 7'd7,   1'b0, 66'd0},
        {64'h0000_0000_0000_0003, 7'd4,   1'b0, 66'd0},
        {64'h0000_0000_FFFF_FFFF, 7'd9,   1'b0, 66'd0},
        {64'hFFFF_FFFF_0000_0001, 7'd16,  1'b0, 66'd0}
    };

    logic clk;
    logic rst_n;

    olis_in_if  in_ch ();
    olis_out_if out_ch ();

    odd_limb_inverse_limb_stream_unit #(
        .MAX_LIMBS(MAX_LIMBS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    limb_result_t pending_limbs [$];
    stim_row_t    tx_row;
    bit           tx_calm;
    bit           rx_calm;
    int           rx_hold;
    int           rx_phase;
    int           failures;
    int           operands_taken;
    int           even_operands;
    int           limbs_checked;
    int           longest_run;
    int           quiet_cycles;
    logic         in_fire;
    logic         out_fire;
    limb_result_t got_limb;
    limb_result_t due_limb;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out every limb of the 2-adic inverse stream and queues it; an even operand queues one error result.
    function automatic void predict_inverse_limbs(input logic [LIMB_W-1:0] a,
                                                  input logic [COUNT_W-1:0] count);
        logic [LIMB_W-1:0] inv;
        logic [LIMB_W-1:0] carry;
        logic [LIMB_W-1:0] p;
        logic [LIMB_W-1:0] sum;
        logic [PROD_W-1:0] prod;
        int                n;
        if (!a[0])
        begin
            pending_limbs.push_back('{limb: '0, last: 1'b1, error: 1'b1});
        end
        else
        begin
            n = (count == 0) ? 1 : (count > MAX_LIMBS) ? MAX_LIMBS : int'(count);
            if (n > longest_run)
                longest_run = n;
            // An odd a is its own inverse modulo 8, so five Newton steps reach 64 bits.
            inv = a;
            repeat (5) inv = inv * (64'd2 - a * inv);
            pending_limbs.push_back('{limb: inv, last: (n == 1), error: 1'b0});
            prod = {64'd0, inv} * {64'd0, a};
            carry = prod[PROD_W-1:LIMB_W];
            for (int i = 1; i < n; i++)
            begin
                p = (64'd0 - inv) * carry;
                pending_limbs.push_back('{limb: p, last: (i + 1 == n), error: 1'b0});
                prod = {64'd0, p} * {64'd0, a};
                sum = carry + prod[LIMB_W-1:0];
                carry = prod[PROD_W-1:LIMB_W] + LIMB_W'(sum < prod[LIMB_W-1:0]);
            end
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Holds valid across back-to-back transfers so it never drops and rises in one step.
    task automatic send_item(input stim_row_t row);
        int gap;
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operand    <= row.operand;
        in_ch.limb_count <= row.count;
        tx_row = row;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Valid is dropped first so the operand just taken is not offered again.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_limbs.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                rx_phase = $urandom_range(50, 300);
            end
            else
            begin
                rx_phase--;
            end
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    rx_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire  = in_ch.valid && in_ch.ready;
            out_fire = out_ch.valid && out_ch.ready;
            if (in_fire)
            begin
                operands_taken++;
                if (!tx_row.operand[0])
                    even_operands++;
                if (tx_row.typed)
                    pending_limbs.push_back(tx_row.want);
                else
                    predict_inverse_limbs(tx_row.operand, tx_row.count);
            end
            if (out_fire)
            begin
                got_limb = '{limb: out_ch.limb, last: out_ch.last, error: out_ch.error};
                limbs_checked++;
                if (pending_limbs.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected limb %h last %b error %b", $time,
                             got_limb.limb, got_limb.last, got_limb.error);
                end
                else
                begin
                    due_limb = pending_limbs.pop_front();
                    if (got_limb.limb !== due_limb.limb)
                    begin
                        failures++;
                        $display("%0t: limb expected %h actual %h", $time,
                                 due_limb.limb, got_limb.limb);
                    end
                    if (got_limb.last !== due_limb.last)
                    begin
                        failures++;
                        $display("%0t: last expected %b actual %b", $time,
                                 due_limb.last, got_limb.last);
                    end
                    if (got_limb.error !== due_limb.error)
                    begin
                        failures++;
                        $display("%0t: error expected %b actual %b", $time,
                                 due_limb.error, got_limb.error);
                    end
                end
            end
            quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= SILENCE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d limbs outstanding", $time,
                         SILENCE_LIMIT, pending_limbs.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        int          roll;
        logic [6:0]  seed_walk;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.operand    = '0;
        in_ch.limb_count = '0;
        out_ch.ready     = 1'b0;
        tx_calm          = 1'b0;
        rx_calm          = 1'b0;
        rx_hold          = 0;
        rx_phase         = 0;
        failures         = 0;
        operands_taken   = 0;
        even_operands    = 0;
        limbs_checked    = 0;
        longest_run      = 0;
        quiet_cycles     = 0;
        seed_walk        = '0;
        tx_row           = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i]);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if (i % 40 == 39)
                wait_drained();
            row = '0;
            row.operand = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
                row.operand = row.operand & {$urandom, $urandom} & {$urandom, $urandom};
            if ($urandom_range(0, 99) < 10)
            begin
                row.operand[0] = 1'b0;
            end
            else
            begin
                // Odd operands walk the seed index so the table entries are used in turn.
                row.operand[0]   = 1'b1;
                row.operand[7:1] = seed_walk;
                seed_walk++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 55)
                row.count = COUNT_W'($urandom_range(1, 4));
            else if (roll < 80)
                row.count = COUNT_W'($urandom_range(5, 16));
            else if (roll < 90)
                row.count = COUNT_W'($urandom_range(17, 63));
            else if (roll < 94)
                row.count = COUNT_W'(MAX_LIMBS);
            else if (roll < 97)
                row.count = COUNT_W'(0);
            else
                row.count = COUNT_W'($urandom_range(MAX_LIMBS + 1, 127));
            send_item(row);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d operands (%0d even) and %0d result limbs, longest run %0d limbs.",
                 operands_taken, even_operands, limbs_checked, longest_run);
        $display("Detected %0d field mismatches.", failures);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
